### rtl/dmm_pkg.sv
`timescale 1ns / 1ps

package dmm_pkg;

  localparam int LANES      = 4;
  localparam int FIELD_BITS = 16;
  localparam int GAIN_BITS  = 16;
  localparam int POS_BITS   = 16;
  localparam int REG_BITS   = 64;
  localparam int IDX_BITS   = 4;

  // register map
  localparam logic [IDX_BITS-1:0] REG_GAIN_ROW0 = 4'd0;
  localparam logic [IDX_BITS-1:0] REG_TAP_ROW0  = 4'd4;
  localparam logic [IDX_BITS-1:0] REG_COUNT     = 4'd8;

  // operand source of one path
  localparam logic [1:0] OPND_ZERO = 2'd0;
  localparam logic [1:0] OPND_MEM  = 2'd1;
  localparam logic [1:0] OPND_NEW  = 2'd2;

  typedef logic signed [FIELD_BITS-1:0] field_t;

  typedef struct packed {
    logic [LANES-1:0][FIELD_BITS-1:0] sample;
    logic [POS_BITS-1:0]              pos;
    logic                             full;   // every history slot written
  } job_t;

  typedef struct packed {
    logic [1:0] level;
    logic       pop;
  } queue_status_t;

  typedef struct packed {
    logic [1:0] outstanding;
    logic [1:0] fifo_level;
  } back_status_t;

endpackage

### rtl/delay_matrix_mixer_core.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake           Beat
// in       in   in_valid/in_stall   sample_ch0..3 (one frame)
// out      out  out_valid/out_stall out_ch0..3 (one mixed frame)
// cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data (one register)
//
// Rate: rows are read in turn by the history read port of each source lane,
//   one tap per output row per cycle while the result queue has room.
// Path: job queue, row reads, multiply, sum, round/saturate into the
//   2-deep result queue.
// Reset: rst is synchronous; registers, write position and queues clear.
//   History slots never written read as zero (fill flag, no clearing pass).
// Stalls: in_stall rises only when the job queue is full; out_stall holds
//   results in the result queue and backs up the mixer after two frames.

module delay_matrix_mixer_core import dmm_pkg::*; #(
  parameter int CHANNELS    = 4,
  parameter int MAX_DELAY   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  sample_ch0,
  input  logic signed [15:0]  sample_ch1,
  input  logic signed [15:0]  sample_ch2,
  input  logic signed [15:0]  sample_ch3,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_ch0,
  output logic signed [15:0]  out_ch1,
  output logic signed [15:0]  out_ch2,
  output logic signed [15:0]  out_ch3,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0] cfg_data
);

  // config registers: gain rows then tap delay rows
  logic [LANES-1:0][REG_BITS-1:0] gain_rows;
  logic [LANES-1:0][REG_BITS-1:0] tap_rows;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_rows <= '0;
      tap_rows  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      priority if (cfg_index < REG_TAP_ROW0) begin
        gain_rows[2'(cfg_index - REG_GAIN_ROW0)] <= cfg_data;
      end else if (cfg_index < REG_COUNT) begin
        tap_rows[2'(cfg_index - REG_TAP_ROW0)] <= cfg_data;
      end
      // indexes past the map are dropped
    end
  end

  job_t          job;
  logic          job_valid;
  logic          job_pop;
  queue_status_t q_status;
  back_status_t  b_status;
  logic [LANES-1:0][FIELD_BITS-1:0] result;

  // front: accept frames, stamp write position and fill state
  dmm_front #(
    .MAX_DELAY(MAX_DELAY)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_ch0(sample_ch0),
    .sample_ch1(sample_ch1),
    .sample_ch2(sample_ch2),
    .sample_ch3(sample_ch3),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .status    (q_status)
  );

  // back: history lines, tap reads, multiply-accumulate, result queue
  dmm_back #(
    .CHANNELS   (CHANNELS),
    .MAX_DELAY  (MAX_DELAY),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job      (job),
    .job_valid(job_valid),
    .job_pop  (job_pop),
    .gain_rows(gain_rows),
    .tap_rows (tap_rows),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result   (result),
    .status   (b_status)
  );

  assign out_ch0 = $signed(result[0]);
  assign out_ch1 = $signed(result[1]);
  assign out_ch2 = $signed(result[2]);
  assign out_ch3 = $signed(result[3]);

`ifndef SYNTH
  // a frame is never taken from an empty job queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_status.pop |-> (q_status.level != 2'd0))
    else $error("job popped from empty queue");

  // frames in flight never exceed the result queue depth
  a_credit: assert property (@(posedge clk) disable iff (rst)
    (b_status.outstanding != 2'd3) && (b_status.fifo_level <= b_status.outstanding))
    else $error("result credit overrun");

  // nothing is shown right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");
`endif

endmodule

### rtl/dmm_front.sv
`timescale 1ns / 1ps

module dmm_front import dmm_pkg::*; #(
  parameter int MAX_DELAY = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  field_t        sample_ch0,
  input  field_t        sample_ch1,
  input  field_t        sample_ch2,
  input  field_t        sample_ch3,
  output job_t          job,
  output logic          job_valid,
  input  logic          job_pop,
  output queue_status_t status
);

  localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam logic [AW-1:0] LAST = AW'(MAX_DELAY - 1);

  logic [AW-1:0] wp;
  logic          full;
  job_t          queue [2];
  logic          head;
  logic          tail;
  logic [1:0]    level;
  logic          push;
  job_t          entry;

  assign in_stall  = (level == 2'd2);
  assign push      = in_valid && !in_stall;
  assign job_valid = (level != 2'd0);
  assign job       = queue[head];

  always_comb begin
    entry.sample = {sample_ch3, sample_ch2, sample_ch1, sample_ch0};
    entry.pos    = POS_BITS'(wp);
    entry.full   = full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      full  <= 1'b0;
      head  <= 1'b0;
      tail  <= 1'b0;
      level <= 2'd0;
    end else begin
      if (push) begin
        tail <= ~tail;
        if (wp == LAST) begin
          wp   <= '0;
          full <= 1'b1;
        end else begin
          wp <= wp + AW'(1);
        end
      end
      if (job_pop) head <= ~head;
      level <= level + 2'(push) - 2'(job_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) queue[tail] <= entry;
  end

  assign status.level = level;
  assign status.pop   = job_pop;

endmodule

### rtl/dmm_back.sv
`timescale 1ns / 1ps

module dmm_back import dmm_pkg::*; #(
  parameter int CHANNELS    = 4,
  parameter int MAX_DELAY   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  job_t                      job,
  input  logic                      job_valid,
  output logic                      job_pop,
  input  logic [LANES-1:0][REG_BITS-1:0] gain_rows,
  input  logic [LANES-1:0][REG_BITS-1:0] tap_rows,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [LANES-1:0][FIELD_BITS-1:0] result,
  output back_status_t              status
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int PW = SB + GAIN_BITS;
  localparam int SW = PW + 2;
  localparam int QW = SW + 1 - 15;
  localparam logic [FIELD_BITS:0] TAP_LIMIT = (FIELD_BITS+1)'(MAX_DELAY - 1);
  localparam logic [AW:0] DEPTH = (AW+1)'(MAX_DELAY);
  localparam logic signed [QW-1:0] MAX_OUT = QW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [QW-1:0] MIN_OUT = -MAX_OUT - QW'(1);

  // sequencer: one output row per cycle, four rows per frame
  logic       active;
  logic [1:0] step;
  job_t       cur;
  logic [1:0] outstanding;
  logic       out_pop;
  logic       start;
  logic       wr_en;
  logic [AW-1:0] wp;

  assign out_pop = out_valid && !out_stall;
  assign start   = job_valid && (!active || step == 2'd3) &&
                   ((outstanding != 2'd2) || out_pop);
  assign job_pop = start;
  assign wr_en   = active && (step == 2'd0);
  assign wp      = cur.pos[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      step        <= 2'd0;
      outstanding <= 2'd0;
    end else begin
      if (start) begin
        active <= 1'b1;
        step   <= 2'd0;
      end else if (active) begin
        step <= step + 2'd1;
        if (step == 2'd3) active <= 1'b0;
      end
      outstanding <= outstanding + 2'(start) - 2'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (start) cur <= job;
  end

  // address generation and history lines
  logic signed [SB-1:0] samp    [LANES];
  logic [AW-1:0]        addr    [LANES];
  logic [1:0]           sel     [LANES];
  logic signed [SB-1:0] rd_data [LANES];

  for (genvar s = 0; s < LANES; s++) begin : g_lane
    logic [FIELD_BITS-1:0] tap_raw;
    logic [AW-1:0]         tap;
    logic                  ahead;

    // sample is two's complement in its low SB bits
    assign samp[s]  = SB'(cur.sample[s]);
    assign tap_raw  = tap_rows[step][FIELD_BITS*s +: FIELD_BITS];
    assign tap      = ({1'b0, tap_raw} > TAP_LIMIT) ? AW'(MAX_DELAY - 1) : AW'(tap_raw);
    assign ahead    = (wp >= tap);

    always_comb begin
      if (ahead) addr[s] = wp - tap;
      else addr[s] = AW'({1'b0, wp} + DEPTH - {1'b0, tap});
    end

    always_comb begin
      if (s >= CHANNELS) sel[s] = OPND_ZERO;
      else if (tap == '0) sel[s] = OPND_NEW;   // sample of this frame
      else if (cur.full || ahead) sel[s] = OPND_MEM;
      else sel[s] = OPND_ZERO;                 // slot not yet written
    end

    if (s < CHANNELS) begin : g_mem
      logic signed [SB-1:0] line [MAX_DELAY];
      always_ff @(posedge clk) begin
        if (wr_en) line[wp] <= samp[s];
        rd_data[s] <= line[addr[s]];
      end
    end else begin : g_none
      assign rd_data[s] = '0;
    end
  end

  // stage 1: operands
  logic                 s1_valid;
  logic [1:0]           s1_d;
  logic [1:0]           s1_sel  [LANES];
  logic signed [GAIN_BITS-1:0] s1_gain [LANES];
  logic signed [SB-1:0] s1_new  [LANES];

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= active;
  end

  always_ff @(posedge clk) begin
    s1_d <= step;
    for (int s = 0; s < LANES; s++) begin
      s1_sel[s]  <= sel[s];
      s1_gain[s] <= $signed(gain_rows[step][GAIN_BITS*s +: GAIN_BITS]);
      s1_new[s]  <= samp[s];
    end
  end

  // stage 2: products
  logic                 s2_valid;
  logic [1:0]           s2_d;
  logic signed [PW-1:0] s2_prod [LANES];
  logic signed [SB-1:0] opnd    [LANES];

  always_comb begin
    for (int s = 0; s < LANES; s++) begin
      unique case (s1_sel[s])
        OPND_MEM: opnd[s] = rd_data[s];
        OPND_NEW: opnd[s] = s1_new[s];
        default:  opnd[s] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    s2_d <= s1_d;
    for (int s = 0; s < LANES; s++) begin
      s2_prod[s] <= PW'(opnd[s]) * PW'(s1_gain[s]);
    end
  end

  // stage 3: sum
  logic                 s3_valid;
  logic [1:0]           s3_d;
  logic signed [SW-1:0] s3_sum;

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    s3_d   <= s2_d;
    s3_sum <= SW'(s2_prod[0]) + SW'(s2_prod[1]) + SW'(s2_prod[2]) + SW'(s2_prod[3]);
  end

  // round half up, saturate, collect the row
  logic signed [SW:0]   biased;
  logic signed [QW-1:0] quot;
  logic signed [QW-1:0] clamped;
  logic [FIELD_BITS-1:0] res;
  logic [FIELD_BITS-1:0] row [3];
  logic                  push;

  always_comb begin
    biased = (SW+1)'(s3_sum) + (SW+1)'(16384);
    quot   = QW'(biased >>> 15);
    if (quot > MAX_OUT) clamped = MAX_OUT;
    else if (quot < MIN_OUT) clamped = MIN_OUT;
    else clamped = quot;
    if (32'(s3_d) >= CHANNELS) res = '0;
    else res = FIELD_BITS'(clamped);
  end

  assign push = s3_valid && (s3_d == 2'd3);

  always_ff @(posedge clk) begin
    if (s3_valid && s3_d != 2'd3) row[s3_d] <= res;
  end

  // result queue, two frames deep
  logic [LANES-1:0][FIELD_BITS-1:0] fifo [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] level;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (out_pop) rd_ptr <= ~rd_ptr;
      level <= level + 2'(push) - 2'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= {res, row[2], row[1], row[0]};
  end

  assign out_valid = (level != 2'd0);
  assign result    = fifo[rd_ptr];

  assign status.outstanding = outstanding;
  assign status.fifo_level  = level;

endmodule

### bench/tb_delay_matrix_mixer_core.sv
`timescale 1ns / 1ps

module tb_delay_matrix_mixer_core;
  import dmm_pkg::*;

  localparam int DEPTH = 4096;

  // one frame of four samples
  typedef struct packed {
    logic [15:0] c3, c2, c1, c0;
  } frame_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] sample_ch0 = 0, sample_ch1 = 0, sample_ch2 = 0, sample_ch3 = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] out_ch0, out_ch1, out_ch2, out_ch3;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [IDX_BITS-1:0] cfg_index = '0;
  logic [REG_BITS-1:0] cfg_data = '0;

  delay_matrix_mixer_core uut (.*);

  always #10 clk = ~clk;

  // predictor state: registers, per-lane history, write slot
  logic [63:0] gain_row [4];
  logic [63:0] tap_row [4];
  logic signed [15:0] hist [4][DEPTH];
  int unsigned wr_slot;

  frame_t pending_frames[$];   // frames waiting to be driven
  frame_t mix_expected[$];     // mixed frames waiting to come out
  int errors = 0;

  // driver controls
  bit hold_sender = 0;         // sender pauses while set
  int long_hold = 0;           // receiver holds off this many cycles

  // mix one accepted frame into the expected output frame
  function automatic frame_t mix_frame(frame_t f);
    frame_t r;
    logic signed [15:0] smp [4];
    logic [15:0] res [4];
    longint acc, t, y;
    int unsigned tap, idx;
    smp[0] = f.c0; smp[1] = f.c1; smp[2] = f.c2; smp[3] = f.c3;
    for (int s = 0; s < 4; s++) hist[s][wr_slot] = smp[s];
    for (int d = 0; d < 4; d++) begin
      acc = 0;
      for (int s = 0; s < 4; s++) begin
        tap = tap_row[d][16*s +: 16];
        if (tap > DEPTH - 1) tap = DEPTH - 1;
        idx = (wr_slot + DEPTH - tap) % DEPTH;
        acc += longint'($signed(gain_row[d][16*s +: 16])) * longint'(hist[s][idx]);
      end
      // round half up, then floor divide by 2^15
      t = acc + 16384;
      y = t >>> 15;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      res[d] = y[15:0];
    end
    wr_slot = (wr_slot + 1) % DEPTH;
    r.c0 = res[0]; r.c1 = res[1]; r.c2 = res[2]; r.c3 = res[3];
    return r;
  endfunction

  // append one frame to the send queue
  task automatic queue_frame(input frame_t f);
    pending_frames = {pending_frames, f};
  endtask

  // sender: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        mix_expected = {mix_expected,
                        mix_frame({sample_ch3, sample_ch2, sample_ch1, sample_ch0})};
        void'(pending_frames.pop_front());
      end
      if (in_valid && in_stall) begin
        // payload held
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 0;
      end else if (!hold_sender && pending_frames.size() > 0) begin
        in_valid <= 1;
        {sample_ch3, sample_ch2, sample_ch1, sample_ch0} <= pending_frames[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver: stall pattern plus an optional long hold-off
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_stall <= 1;
    end else begin
      stall_phase <= stall_phase + 1;
      // quiet stretches, then busy ones
      if ((stall_phase / 200) % 3 == 0) out_stall <= 0;
      else out_stall <= ($urandom_range(0, 99) < 35);
    end
  end

  // monitor: compare each beat with the oldest expectation
  always @(posedge clk) begin
    frame_t e;
    if (!rst && out_valid && !out_stall) begin
      if (mix_expected.size() == 0) begin
        $display("%0t: unexpected beat %h %h %h %h", $time,
                 out_ch0, out_ch1, out_ch2, out_ch3);
        errors++;
      end else begin
        e = mix_expected.pop_front();
        if (out_ch0 !== e.c0) begin
          $display("%0t: out_ch0 expected %h actual %h", $time, e.c0, out_ch0); errors++;
        end
        if (out_ch1 !== e.c1) begin
          $display("%0t: out_ch1 expected %h actual %h", $time, e.c1, out_ch1); errors++;
        end
        if (out_ch2 !== e.c2) begin
          $display("%0t: out_ch2 expected %h actual %h", $time, e.c2, out_ch2); errors++;
        end
        if (out_ch3 !== e.c3) begin
          $display("%0t: out_ch3 expected %h actual %h", $time, e.c3, out_ch3); errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_frames.size() != 0 || in_valid || mix_expected.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx < REG_TAP_ROW0) gain_row[idx[1:0]] = val;
    else if (idx < REG_COUNT) tap_row[2'(idx - REG_TAP_ROW0)] = val;
    // idle gap between writes
    @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rnd_gain();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // taps mostly short so history is revisited, sometimes past the line end
  function automatic logic [15:0] rnd_tap();
    case ($urandom_range(0, 7))
      0: return 16'hffff;
      1: return 16'(DEPTH - 1);
      2: return 16'(DEPTH);
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic random_config();
    for (int r = 0; r < 4; r++)
      write_reg(IDX_BITS'(REG_GAIN_ROW0 + r),
                {rnd_gain(), rnd_gain(), rnd_gain(), rnd_gain()});
    for (int r = 0; r < 4; r++)
      write_reg(IDX_BITS'(REG_TAP_ROW0 + r),
                {rnd_tap(), rnd_tap(), rnd_tap(), rnd_tap()});
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++)
      queue_frame({rnd_sample(), rnd_sample(), rnd_sample(), rnd_sample()});
  endtask

  initial begin
    for (int r = 0; r < 4; r++) begin
      gain_row[r] = 0; tap_row[r] = 0;
    end
    for (int s = 0; s < 4; s++)
      for (int i = 0; i < DEPTH; i++) hist[s][i] = 0;
    wr_slot = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: all gains zero first (reset values)
    queue_frame({16'h7fff, 16'h8000, 16'h0001, 16'hffff});
    wait_drained();
    // full-scale gains, taps 0 / 1 / max / past end: saturation both ways
    for (int r = 0; r < 4; r++) write_reg(IDX_BITS'(REG_GAIN_ROW0 + r), {4{16'h7fff}});
    write_reg(IDX_BITS'(REG_GAIN_ROW0 + 1), {4{16'h8000}});
    write_reg(IDX_BITS'(REG_TAP_ROW0 + 0), 64'h0);
    write_reg(IDX_BITS'(REG_TAP_ROW0 + 1), {16'd0, 16'd1, 16'd2, 16'd3});
    write_reg(IDX_BITS'(REG_TAP_ROW0 + 2), {4{16'hffff}});
    write_reg(IDX_BITS'(REG_TAP_ROW0 + 3), {16'd4095, 16'd4096, 16'd1, 16'd0});
    for (int i = 0; i < 6; i++) begin
      queue_frame({4{16'h7fff}});
      queue_frame({4{16'h8000}});
    end
    // odd samples under full-scale gains, then rounding at the half with gain 0.5
    queue_frame({16'h0001, 16'hffff, 16'h0003, 16'hfffd});
    queue_frame({16'h0000, 16'h5555, 16'haaaa, 16'h0000});
    wait_drained();
    write_reg(IDX_BITS'(REG_GAIN_ROW0 + 2), {16'h4000, 16'hc000, 16'h4000, 16'h4000});
    write_reg(4'd9, 64'hdead_beef_0000_1111);    // unused index, ignored
    queue_frame({16'h0001, 16'hffff, 16'h0003, 16'hfffd});
    queue_frame({16'h7fff, 16'h8000, 16'h0001, 16'h0000});
    wait_drained();

    // random phases with fresh settings
    for (int p = 0; p < 9; p++) begin
      random_config();
      queue_random(150);
      if (p == 3) begin
        // long hold-off so the block backs up and stalls its input
        long_hold = 300;
      end
      wait_drained();
    end
    // sender waits for everything, then a last burst
    hold_sender = 1;
    queue_random(5);
    repeat (30) @(posedge clk);
    hold_sender = 0;
    wait_drained();

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

### filelist.f
rtl/dmm_pkg.sv
rtl/dmm_front.sv
rtl/dmm_back.sv
rtl/delay_matrix_mixer_core.sv
bench/tb_delay_matrix_mixer_core.sv
